[src/curb_pkg.sv]
// Shared types and constants for the coalescing unmap request buffer.
// No dependencies; the design files that use it refer to it by scoped names, the testbench imports it.
`default_nettype none

package curb_pkg;

  // Defaults for the top-level parameters
  localparam int LogDepth  = 6;
  localparam int SpaceBits = 16;

  // Fixed field widths of the request and result beats
  localparam int SpaceIdW = 16;
  localparam int AddrW    = 64;
  localparam int SizeW    = 6;
  localparam int RightsW  = 3;

  // Largest size exponent; an entry this big never merges
  localparam logic [SizeW-1:0] SizeMax = 6'd63;

  // Request modes
  localparam logic ModeAdd   = 1'b0;
  localparam logic ModeFlush = 1'b1;

  // Controller tells the top level to load the output register from RAM read data
  typedef struct packed {
    logic valid;
    logic last;
  } emit_t;

endpackage

`default_nettype wire

[src/curb_if.sv]
// Valid/ready channel interfaces for request and result beats.
// Depends on curb_pkg for field widths.
`default_nettype none

interface curb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [curb_pkg::SpaceIdW-1:0] space_id;
  logic [curb_pkg::AddrW-1:0]    req_addr;
  logic [curb_pkg::SizeW-1:0]    size_log2;
  logic [curb_pkg::RightsW-1:0]  rights;

  modport source (output valid, mode, space_id, req_addr, size_log2, rights, input ready);
  modport sink   (input valid, mode, space_id, req_addr, size_log2, rights, output ready);
endinterface

interface curb_out_if;
  logic                         valid;
  logic                         ready;
  logic [curb_pkg::SpaceIdW-1:0] out_space_id;
  logic [curb_pkg::AddrW-1:0]    out_addr;
  logic [curb_pkg::SizeW-1:0]    out_size_log2;
  logic [curb_pkg::RightsW-1:0]  out_rights;
  logic                         last;

  modport source (output valid, out_space_id, out_addr, out_size_log2, out_rights, last,
                  input ready);
  modport sink   (input valid, out_space_id, out_addr, out_size_log2, out_rights, last,
                  output ready);
endinterface

`default_nettype wire

[src/curb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module curb_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/curb_buddy.sv]
// Buddy test between a stored lower entry and the pending upper entry.
// Depends on curb_pkg for field widths and the size limit.
`default_nettype none

module curb_buddy #(
  parameter int SpW = 16
) (
  input  wire logic [SpW-1:0]               lo_space_i,
  input  wire logic [curb_pkg::AddrW-1:0]   lo_base_i,
  input  wire logic [curb_pkg::SizeW-1:0]   lo_size_i,
  input  wire logic [curb_pkg::RightsW-1:0] lo_rights_i,
  input  wire logic [SpW-1:0]               hi_space_i,
  input  wire logic [curb_pkg::AddrW-1:0]   hi_base_i,
  input  wire logic [curb_pkg::SizeW-1:0]   hi_size_i,
  input  wire logic [curb_pkg::RightsW-1:0] hi_rights_i,
  output logic                              merge_o
);

  logic [curb_pkg::AddrW-1:0] step;
  logic [curb_pkg::AddrW-1:0] lo_end;
  logic [curb_pkg::AddrW-1:0] align_mask;
  logic [curb_pkg::SizeW:0]   size_p1;

  always_comb begin
    step       = {{(curb_pkg::AddrW-1){1'b0}}, 1'b1} << lo_size_i;
    lo_end     = lo_base_i + step;  // wraps at the top; a wrapped pair fails alignment
    size_p1    = {1'b0, lo_size_i} + {{curb_pkg::SizeW{1'b0}}, 1'b1};
    align_mask = ~({curb_pkg::AddrW{1'b1}} << size_p1);
    merge_o    = (lo_size_i != curb_pkg::SizeMax) &&
                 (lo_size_i == hi_size_i) &&
                 (lo_end == hi_base_i) &&
                 ((lo_base_i & align_mask) == '0) &&
                 (lo_space_i == hi_space_i) &&
                 (lo_rights_i == hi_rights_i);
  end

endmodule

`default_nettype wire

[src/curb_ctrl.sv]
// Sequencer for the log: append with merge cascade, and flush walk over the RAM.
// Depends on curb_pkg and curb_buddy; drives the ports of a curb_ram instance.
`default_nettype none

module curb_ctrl #(
  parameter int Depth = 6,
  parameter int SpW   = 16,
  localparam int EntW = SpW + curb_pkg::AddrW + curb_pkg::SizeW + curb_pkg::RightsW,
  localparam int IdxW = $clog2(Depth)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            in_mode_i,
  input  wire logic [EntW-1:0] in_entry_i,
  output logic                 ram_we_o,
  output logic [IdxW-1:0]      ram_waddr_o,
  output logic [EntW-1:0]      ram_wdata_o,
  output logic                 ram_re_o,
  output logic [IdxW-1:0]      ram_raddr_o,
  input  wire logic [EntW-1:0] ram_rdata_i,
  input  wire logic            out_free_i,
  output curb_pkg::emit_t      emit_o
);

  localparam int CntW  = $clog2(Depth + 1);
  localparam int OffSz = curb_pkg::RightsW;
  localparam int OffBs = OffSz + curb_pkg::SizeW;
  localparam int OffSp = OffBs + curb_pkg::AddrW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StChk  = 3'd1;  // issue read of the entry below, or commit at 0
  localparam logic [2:0] StCmp  = 3'd2;  // buddy test against read data
  localparam logic [2:0] StFrd  = 3'd3;  // flush: read entry
  localparam logic [2:0] StFout = 3'd4;  // flush: hand entry to output register

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [EntW-1:0] cur_q, cur_d;
  logic            merge;
  logic            commit;

  curb_buddy #(
    .SpW (SpW)
  ) u_buddy (
    .lo_space_i  (ram_rdata_i[OffSp +: SpW]),
    .lo_base_i   (ram_rdata_i[OffBs +: curb_pkg::AddrW]),
    .lo_size_i   (ram_rdata_i[OffSz +: curb_pkg::SizeW]),
    .lo_rights_i (ram_rdata_i[0 +: curb_pkg::RightsW]),
    .hi_space_i  (cur_q[OffSp +: SpW]),
    .hi_base_i   (cur_q[OffBs +: curb_pkg::AddrW]),
    .hi_size_i   (cur_q[OffSz +: curb_pkg::SizeW]),
    .hi_rights_i (cur_q[0 +: curb_pkg::RightsW]),
    .merge_o     (merge)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = cur_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q - IdxW'(1);
    emit_o      = '0;
    commit      = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == curb_pkg::ModeFlush) begin
            if (cnt_q != '0) begin
              idx_d   = '0;
              state_d = StFrd;
            end
          end else begin
            cur_d   = in_entry_i;
            idx_d   = cnt_q[IdxW-1:0];
            state_d = StChk;
          end
        end
      end
      StChk: begin
        if (idx_q == '0) begin
          commit = 1'b1;
        end else begin
          ram_re_o = 1'b1;
          state_d  = StCmp;
        end
      end
      StCmp: begin
        if (merge) begin
          // merged entry replaces the lower one and keeps cascading downward
          cur_d = {ram_rdata_i[EntW-1:OffBs],
                   ram_rdata_i[OffSz +: curb_pkg::SizeW] + curb_pkg::SizeW'(1),
                   ram_rdata_i[0 +: curb_pkg::RightsW]};
          idx_d   = idx_q - IdxW'(1);
          state_d = StChk;
        end else begin
          commit = 1'b1;
        end
      end
      StFrd: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q;
        state_d     = StFout;
      end
      StFout: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.last  = (CntW'(idx_q) + CntW'(1)) == cnt_q;
          if (emit_o.last) begin
            cnt_d   = '0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StFrd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (commit) begin
      ram_we_o = 1'b1;
      cnt_d    = CntW'(idx_q) + CntW'(1);
      if (idx_q == LastIdx) begin
        idx_d   = '0;
        state_d = StFrd;
      end else begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

[src/coalescing_unmap_request_buffer.sv]
// Top level of the coalescing unmap request buffer: alignment, log RAM, output register.
// Depends on curb_pkg, curb_if, curb_ram and curb_ctrl.
`default_nettype none

// Collects unmap requests in an ordered log held in a single RAM of LOG_DEPTH entries
// and merges each new request with its buddy below it, repeatedly. Each buddy test of
// an add reads the entry below through the registered RAM read port and compares it
// in the next cycle. When the entry ends up at the bottom of the log it is written from
// the check state, else from the compare state of its failing test. A flush, or an add
// that fills the log, walks the RAM on the same read port, reading each entry and then
// handing it to the output register, and waits on any output stall. Input ready is high
// only while the sequencer is idle; the output register lets the last result wait while
// the next request is taken. The log needs no clearing after reset.
module coalescing_unmap_request_buffer #(
  parameter int LOG_DEPTH  = curb_pkg::LogDepth,
  parameter int SPACE_BITS = curb_pkg::SpaceBits
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  curb_in_if.sink   in_i,
  curb_out_if.source out_o
);

  localparam int IdW  = curb_pkg::SpaceIdW;
  localparam int SpW  = (SPACE_BITS < IdW) ? SPACE_BITS : IdW;
  localparam int EntW = SpW + curb_pkg::AddrW + curb_pkg::SizeW + curb_pkg::RightsW;
  localparam int IdxW = $clog2(LOG_DEPTH);
  localparam int OffSz = curb_pkg::RightsW;
  localparam int OffBs = OffSz + curb_pkg::SizeW;
  localparam int OffSp = OffBs + curb_pkg::AddrW;

  logic [EntW-1:0]            in_entry;
  logic [curb_pkg::AddrW-1:0] in_base;
  logic                       ram_we, ram_re;
  logic [IdxW-1:0]            ram_waddr, ram_raddr;
  logic [EntW-1:0]            ram_wdata, ram_rdata;
  logic                       out_free;
  curb_pkg::emit_t            emit;

  logic                           out_valid_q;
  logic [IdW-1:0]                 out_space_q;
  logic [curb_pkg::AddrW-1:0]     out_addr_q;
  logic [curb_pkg::SizeW-1:0]     out_size_q;
  logic [curb_pkg::RightsW-1:0]   out_rights_q;
  logic                           out_last_q;

  assign in_base  = in_i.req_addr & ({curb_pkg::AddrW{1'b1}} << in_i.size_log2);
  assign in_entry = {in_i.space_id[SpW-1:0], in_base, in_i.size_log2, in_i.rights};

  curb_ctrl #(
    .Depth (LOG_DEPTH),
    .SpW   (SpW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_mode_i   (in_i.mode),
    .in_entry_i  (in_entry),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_free_i  (out_free),
    .emit_o      (emit)
  );

  curb_ram #(
    .Width (EntW),
    .Depth (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_space_q  <= IdW'(ram_rdata[OffSp +: SpW]);
      out_addr_q   <= ram_rdata[OffBs +: curb_pkg::AddrW];
      out_size_q   <= ram_rdata[OffSz +: curb_pkg::SizeW];
      out_rights_q <= ram_rdata[0 +: curb_pkg::RightsW];
      out_last_q   <= emit.last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_space_id  = out_space_q;
  assign out_o.out_addr      = out_addr_q;
  assign out_o.out_size_log2 = out_size_q;
  assign out_o.out_rights    = out_rights_q;
  assign out_o.last          = out_last_q;

endmodule

`default_nettype wire

[src/curb_checker.sv]
// Port-level checks for coalescing_unmap_request_buffer, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module curb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_mode_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_addr_i,
  input wire logic        out_last_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_addr_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // mid flush run no request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("request accepted in the middle of a flush run");

  // an accepted add beat takes the sequencer out of idle, so ready falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_mode_i |=> !in_ready_i)
    else $error("ready right after an add beat");

endmodule

bind coalescing_unmap_request_buffer curb_checker u_curb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_addr_i  (out_o.out_addr),
  .out_last_i  (out_o.last)
);

`default_nettype wire

[tb/coalescing_unmap_request_buffer_tb.sv]
// Testbench for the coalescing unmap request buffer: directed and random request beats,
// a predictor of the merging log, and an in-order check of every emitted entry.
// Depends on curb_pkg, curb_if and the top level coalescing_unmap_request_buffer.
`default_nettype none

module coalescing_unmap_request_buffer_tb;
  import curb_pkg::*;

  localparam int TimeoutCycles = 400_000;
  localparam int DrainCycles   = 40;
  localparam logic [63:0] SpaceMask = (64'd1 << SpaceBits) - 64'd1;

  typedef struct packed {
    logic                mode;
    logic [SpaceIdW-1:0] space_id;
    logic [AddrW-1:0]    req_addr;
    logic [SizeW-1:0]    size_log2;
    logic [RightsW-1:0]  rights;
  } unmap_req_t;

  typedef struct packed {
    logic [SpaceIdW-1:0] space_id;
    logic [AddrW-1:0]    addr;
    logic [SizeW-1:0]    size_log2;
    logic [RightsW-1:0]  rights;
    logic                last;
  } unmap_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  curb_in_if  req_if ();
  curb_out_if rsp_if ();

  coalescing_unmap_request_buffer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted log contents
  logic [SpaceIdW-1:0] log_space  [LogDepth];
  logic [AddrW-1:0]    log_base   [LogDepth];
  logic [SizeW-1:0]    log_size   [LogDepth];
  logic [RightsW-1:0]  log_rights [LogDepth];
  int                  log_count;

  unmap_entry_t expected_entries[$];
  int           fail_count;

  bit   no_idle;
  int   burst_left;
  logic [7:0] stall_pattern;
  logic [2:0] stall_phase;

  function automatic bit are_buddies(int lo, int hi);
    int s;
    s = int'(log_size[lo]);
    if (s >= SizeMax) return 1'b0;
    if (log_size[hi] != log_size[lo]) return 1'b0;
    if (log_base[lo] + (64'd1 << s) != log_base[hi]) return 1'b0;
    if ((log_base[lo] & ((64'd1 << (s + 1)) - 64'd1)) != 64'd0) return 1'b0;
    return log_space[lo] == log_space[hi] && log_rights[lo] == log_rights[hi];
  endfunction

  function automatic void drain_log();
    unmap_entry_t e;
    for (int k = 0; k < log_count; k++) begin
      e.space_id  = log_space[k];
      e.addr      = log_base[k];
      e.size_log2 = log_size[k];
      e.rights    = log_rights[k];
      e.last      = (k == log_count - 1);
      expected_entries.push_back(e);
    end
    log_count = 0;
  endfunction

  function automatic void coalesce_request(unmap_req_t r);
    int idx;
    if (r.mode == ModeFlush) begin
      drain_log();
      return;
    end
    idx = log_count;
    log_count++;
    log_space[idx]  = r.space_id & SpaceMask[SpaceIdW-1:0];
    log_base[idx]   = r.req_addr & ({AddrW{1'b1}} << r.size_log2);
    log_size[idx]   = r.size_log2;
    log_rights[idx] = r.rights;
    // cascade down while the new block pairs with the one below
    while (idx > 0 && are_buddies(idx - 1, idx)) begin
      log_size[idx-1] = log_size[idx-1] + 1'b1;
      log_count--;
      idx--;
    end
    if (log_count == LogDepth) drain_log();
  endfunction

  function automatic unmap_req_t add_req(logic [SpaceIdW-1:0] space, logic [AddrW-1:0] addr,
                                         logic [SizeW-1:0] size, logic [RightsW-1:0] rights);
    unmap_req_t r;
    r.mode      = ModeAdd;
    r.space_id  = space;
    r.req_addr  = addr;
    r.size_log2 = size;
    r.rights    = rights;
    return r;
  endfunction

  // Flush payload is don't-care, so it carries noise
  function automatic unmap_req_t flush_req();
    unmap_req_t r;
    r = add_req(16'($urandom_range(0, 65535)), {$urandom, $urandom},
                6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
    r.mode = ModeFlush;
    return r;
  endfunction

  task automatic send_beat(input unmap_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.mode      <= r.mode;
    req_if.space_id  <= r.space_id;
    req_if.req_addr  <= r.req_addr;
    req_if.size_log2 <= r.size_log2;
    req_if.rights    <= r.rights;
    do @(posedge clk_i); while (!req_if.ready);
    coalesce_request(r);
  endtask

  // Result side: check each beat, then pick next ready from the stall pattern unless no_idle is set
  always @(posedge clk_i) begin : check_beats
    unmap_entry_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.space_id  = rsp_if.out_space_id;
        got.addr      = rsp_if.out_addr;
        got.size_log2 = rsp_if.out_size_log2;
        got.rights    = rsp_if.out_rights;
        got.last      = rsp_if.last;
        if (expected_entries.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: space %h addr %h size %0d rights %h last %b",
                     got.space_id, got.addr, got.size_log2, got.rights, got.last);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          if (got.space_id !== want.space_id || got.addr !== want.addr ||
              got.size_log2 !== want.size_log2 || got.rights !== want.rights ||
              got.last !== want.last) begin
            if (fail_count < 10) begin
              $display("mismatch: exp space %h addr %h size %0d rights %h last %b",
                       want.space_id, want.addr, want.size_log2, want.rights, want.last);
              $display("          got space %h addr %h size %0d rights %h last %b",
                       got.space_id, got.addr, got.size_log2, got.rights, got.last);
            end
            fail_count++;
          end
        end
      end
      stall_phase <= stall_phase + 3'd1;
      if (stall_phase == 3'd7 && $urandom_range(0, 7) == 0)
        stall_pattern <= 8'($urandom_range(1, 255));
      rsp_if.ready <= no_idle || stall_pattern[stall_phase];
    end
  end

  task automatic test_empty_flush();
    send_beat(flush_req());
  endtask

  // Extremes of address, size, space and rights; a size 63 entry never merges
  task automatic test_field_extremes();
    send_beat(add_req(16'hffff, {AddrW{1'b1}}, 6'd0, 3'd7));
    send_beat(add_req(16'h0000, {AddrW{1'b1}}, 6'd63, 3'd0));
    send_beat(add_req(16'h0000, 64'd0, 6'd0, 3'd0));
    send_beat(flush_req());
  endtask

  // Four 4K pages with junk low bits collapse into one 16K block
  task automatic test_merge_cascade();
    send_beat(add_req(16'd5, 64'h0abc, 6'd12, 3'd3));
    send_beat(add_req(16'd5, 64'h1fff, 6'd12, 3'd3));
    send_beat(add_req(16'd5, 64'h2000, 6'd12, 3'd3));
    send_beat(add_req(16'd5, 64'h3123, 6'd12, 3'd3));
    send_beat(flush_req());
  endtask

  task automatic test_size_limit();
    send_beat(add_req(16'd9, 64'h0, 6'd62, 3'd5));
    send_beat(add_req(16'd9, 64'h4000_0000_0000_0000, 6'd62, 3'd5));
    send_beat(add_req(16'd9, 64'h8000_0000_0000_0000, 6'd63, 3'd5));
    send_beat(flush_req());
  endtask

  // Six adds, each after the first missing a buddy rule; the sixth fills the log
  task automatic test_fill_without_merge();
    send_beat(add_req(16'd7, 64'hffff_ffff_ffff_f000, 6'd12, 3'd1));
    send_beat(add_req(16'd7, 64'h0, 6'd12, 3'd1));          // wraps, lower unaligned
    send_beat(add_req(16'd8, 64'h1000, 6'd12, 3'd1));       // space differs
    send_beat(add_req(16'd8, 64'h2000, 6'd13, 3'd1));       // size differs
    send_beat(add_req(16'd8, 64'h4000, 6'd13, 3'd1));
    send_beat(add_req(16'd8, 64'h6000, 6'd13, 3'd6));       // rights differ
    send_beat(flush_req());
  endtask

  // Mostly buddy chains built on the newest entry, some fresh aligned runs, noise and flushes
  task automatic test_random_traffic(input int n_items);
    unmap_req_t r;
    int pick, top, extra;
    for (int n = 0; n < n_items; n++) begin
      no_idle = (n < n_items / 6);
      pick = $urandom_range(0, 99);
      r = add_req(16'($urandom_range(0, 3)), {$urandom, $urandom},
                  6'($urandom_range(0, 20)), 3'($urandom_range(0, 7)));
      if (pick < 8) begin
        r = flush_req();
      end else if (pick < 60 && log_count > 0) begin
        top = log_count - 1;
        r.space_id  = log_space[top];
        r.rights    = log_rights[top];
        r.size_log2 = log_size[top];
        r.req_addr  = (log_base[top] + (64'd1 << log_size[top])) |
                      (r.req_addr & ~({AddrW{1'b1}} << log_size[top]));
      end else if (pick < 80) begin
        extra = $urandom_range(0, 4);
        r.req_addr = r.req_addr & ({AddrW{1'b1}} << (r.size_log2 + extra));
      end else begin
        r.space_id  = 16'($urandom_range(0, 65535));
        r.size_log2 = 6'($urandom_range(0, 63));
      end
      send_beat(r);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mode      = ModeAdd;
    req_if.space_id  = '0;
    req_if.req_addr  = '0;
    req_if.size_log2 = '0;
    req_if.rights    = '0;
    rsp_if.ready     = 1'b0;
    stall_pattern    = 8'hb5;
    stall_phase      = 3'd0;
    log_count        = 0;
    fail_count       = 0;
    no_idle          = 1'b0;
    burst_left       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_flush();
    test_field_extremes();
    test_merge_cascade();
    test_size_limit();
    test_fill_without_merge();
    test_random_traffic(250);
    send_beat(flush_req());
    req_if.valid <= 1'b0;

    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 20);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

[coalescing_unmap_request_buffer.f]
src/curb_pkg.sv
src/curb_if.sv
src/curb_ram.sv
src/curb_buddy.sv
src/curb_ctrl.sv
src/coalescing_unmap_request_buffer.sv
src/curb_checker.sv
tb/coalescing_unmap_request_buffer_tb.sv
